// File: hw/rtl/tfdi_pkg.sv
// Shared types and constants for the triangle fragment depth interpolator.
// No dependencies.
package tfdi_pkg;

    localparam int SCREEN_WIDTH  = 512;
    localparam int SCREEN_HEIGHT = 512;
    localparam int STORE_DEPTH   = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);

    localparam int COORD_W = 9;
    localparam int SCR_W   = 13;
    localparam int DEPTH_W = 15;
    localparam int TEX_W   = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int CROSS_W = 22;
    localparam int AREA_W  = 20;
    localparam int MUL_W   = 18;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 34;
    localparam int W_W     = 17;
    localparam int QUO_W   = 16;
    localparam int FRAC_W  = 15;

    localparam logic [3:0] DIV_LAST   = 4'd14;
    localparam logic [3:0] CROSS_LAST = 4'd5;
    localparam logic [1:0] LANE_LAST  = 2'd2;
    localparam logic [1:0] SLOT_NONE  = 2'd3;

    localparam logic [W_W-1:0]            ONE_Q15   = 17'h08000;
    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 15'sh4000;

    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_PIXEL = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        QTY_DEPTH = 2'd0,
        QTY_U     = 2'd1,
        QTY_V     = 2'd2
    } qty_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CROSS,
        ST_CROSS_WAIT,
        ST_CHECK,
        ST_DIV,
        ST_MAC,
        ST_MAC_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clearing;
        logic issue_cross;
        logic check;
        logic div_run;
        logic issue_mac;
        logic finish;
    } ctl_t;

endpackage

// File: hw/rtl/tfdi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tfdi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/triangle_fragment_depth_interpolate_top.sv
// Triangle fragment depth interpolator: vertex store, edge cross products,
// barycentric division, interpolation and depth-buffer test.
// Depends on tfdi_pkg and tfdi_ram.
//
// Usage: drive an item on the input ports with start high; it transfers at a
// rising edge where start is high and busy is low. Each item gives exactly one
// result, shown for one cycle with strobe high; the receiver cannot stall it.
// A vertex load returns its result in the cycle after the transfer and busy
// stays low, so loads may follow every cycle.
// A pixel test holds busy for its whole run: a covered on-screen pixel takes
// 6 cross-product multiplies on one shared 18x18 multiplier, 15 divider
// iterations of the two restoring dividers, 9 interpolation multiplies on
// the same multiplier, plus control and depth-store update; a rejected pixel
// skips the division and interpolation. The depth store read is issued
// at the transfer; the write-back happens in the last cycle.
// Reset: vertices go to zero and the depth store is swept to the most
// negative depth, one entry per cycle, with busy high until the whole
// store is swept; only then can the first item transfer.
module triangle_fragment_depth_interpolate_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                opcode,
    input  logic [1:0]                          vertex_slot,
    input  logic [tfdi_pkg::COORD_W-1:0]        x_coord,
    input  logic [tfdi_pkg::COORD_W-1:0]        y_coord,
    input  logic signed [tfdi_pkg::DEPTH_W-1:0] vertex_depth,
    input  logic [tfdi_pkg::TEX_W-1:0]          tex_u,
    input  logic [tfdi_pkg::TEX_W-1:0]          tex_v,
    output logic                                strobe,
    output logic                                written,
    output logic [tfdi_pkg::COORD_W-1:0]        out_x,
    output logic [tfdi_pkg::COORD_W-1:0]        out_y,
    output logic signed [tfdi_pkg::DEPTH_W-1:0] out_depth,
    output logic [tfdi_pkg::TEX_W-1:0]          out_u,
    output logic [tfdi_pkg::TEX_W-1:0]          out_v
);

    import tfdi_pkg::*;

    state_t state_reg;
    state_t state_next;
    ctl_t   ctl;

    logic accept;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic clr_last;

    logic [COORD_W-1:0]        vx_reg [3];
    logic [COORD_W-1:0]        vy_reg [3];
    logic signed [DEPTH_W-1:0] vd_reg [3];
    logic [TEX_W-1:0]          vu_reg [3];
    logic [TEX_W-1:0]          vv_reg [3];

    logic [COORD_W-1:0] px_reg;
    logic [COORD_W-1:0] py_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  in_addr;

    logic signed [DIFF_W-1:0] ex1_reg, ey1_reg, ex2_reg, ey2_reg, dx_reg, dy_reg;

    logic [3:0] step_reg;
    logic [1:0] vi_reg;
    logic [1:0] qi_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic [3:0]               tag_reg;
    logic [1:0]               tag_q_reg;
    logic                     pvalid_reg;
    logic                     pmac_reg;

    logic signed [CROSS_W-1:0] a_reg, b1_reg, b2_reg;
    logic signed [CROSS_W-1:0] na, nb1, nb2, nsum;
    logic covered, onscreen;

    logic [AREA_W-1:0] area_reg;
    logic [AREA_W:0]   r1_reg, r2_reg, r1_sh, r2_sh;
    logic [QUO_W-1:0]  q1_reg, q2_reg;
    logic [W_W-1:0]    w0;
    logic [W_W-1:0]    w_sel;
    logic signed [MUL_W-1:0] val_sel;

    logic signed [ACC_W-1:0] dsum_reg, usum_reg, vsum_reg;
    logic hit_reg;

    logic signed [DEPTH_W-1:0] depth_calc;
    logic signed [DEPTH_W-1:0] stored_depth;
    logic pass;

    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic signed [DEPTH_W-1:0] ram_wdata;

    logic                      strobe_reg, written_reg;
    logic [COORD_W-1:0]        out_x_reg, out_y_reg;
    logic signed [DEPTH_W-1:0] out_depth_reg;
    logic [TEX_W-1:0]          out_u_reg, out_v_reg;

    function automatic logic signed [MUL_W-1:0] sx_diff(input logic signed [DIFF_W-1:0] d);
        sx_diff = {{(MUL_W-DIFF_W){d[DIFF_W-1]}}, d};
    endfunction

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign clr_last = (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1));
    assign in_addr  = ADDR_W'(x_coord) + ADDR_W'(SCREEN_WIDTH) * ADDR_W'(y_coord);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:      if (clr_last) state_next = ST_IDLE;
            ST_IDLE:       if (accept && opcode == OP_PIXEL) state_next = ST_CROSS;
            ST_CROSS:      if (step_reg == CROSS_LAST) state_next = ST_CROSS_WAIT;
            ST_CROSS_WAIT: state_next = ST_CHECK;
            ST_CHECK:      state_next = (covered && onscreen) ? ST_DIV : ST_FINISH;
            ST_DIV:        if (step_reg == DIV_LAST) state_next = ST_MAC;
            ST_MAC:
            begin
                if (vi_reg == LANE_LAST && qi_reg == LANE_LAST)
                begin
                    state_next = ST_MAC_WAIT;
                end
            end
            ST_MAC_WAIT:   state_next = ST_FINISH;
            ST_FINISH:     state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        case (state_reg)
            ST_CLEAR:  ctl.clearing    = 1'b1;
            ST_CROSS:  ctl.issue_cross = 1'b1;
            ST_CHECK:  ctl.check       = 1'b1;
            ST_DIV:    ctl.div_run     = 1'b1;
            ST_MAC:    ctl.issue_mac   = 1'b1;
            ST_FINISH: ctl.finish      = 1'b1;
            default:   ctl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // vertex store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vx_reg[i] <= '0;
                vy_reg[i] <= '0;
                vd_reg[i] <= '0;
                vu_reg[i] <= '0;
                vv_reg[i] <= '0;
            end
        end
        else if (accept && opcode == OP_LOAD && vertex_slot != SLOT_NONE)
        begin
            vx_reg[vertex_slot] <= x_coord;
            vy_reg[vertex_slot] <= y_coord;
            vd_reg[vertex_slot] <= vertex_depth;
            vu_reg[vertex_slot] <= tex_u;
            vv_reg[vertex_slot] <= tex_v;
        end
    end

    // shared multiplier operand select
    assign w0 = ONE_Q15 - {1'b0, q1_reg} - {1'b0, q2_reg};

    always_comb
    begin
        case (vi_reg)
            2'd0:    w_sel = w0;
            2'd1:    w_sel = {1'b0, q1_reg};
            default: w_sel = {1'b0, q2_reg};
        endcase
        case (qi_reg)
            QTY_DEPTH: val_sel = {{(MUL_W-DEPTH_W){vd_reg[vi_reg][DEPTH_W-1]}}, vd_reg[vi_reg]};
            QTY_U:     val_sel = {{(MUL_W-TEX_W){1'b0}}, vu_reg[vi_reg]};
            default:   val_sel = {{(MUL_W-TEX_W){1'b0}}, vv_reg[vi_reg]};
        endcase
        if (ctl.issue_mac)
        begin
            mul_a = {1'b0, w_sel};
            mul_b = val_sel;
        end
        else
        begin
            case (step_reg)
                4'd0:    begin mul_a = sx_diff(ex2_reg); mul_b = sx_diff(ey1_reg); end
                4'd1:    begin mul_a = sx_diff(ex1_reg); mul_b = sx_diff(ey2_reg); end
                4'd2:    begin mul_a = sx_diff(ex1_reg); mul_b = sx_diff(dy_reg);  end
                4'd3:    begin mul_a = sx_diff(dx_reg);  mul_b = sx_diff(ey1_reg); end
                4'd4:    begin mul_a = sx_diff(dx_reg);  mul_b = sx_diff(ey2_reg); end
                default: begin mul_a = sx_diff(ex2_reg); mul_b = sx_diff(dy_reg);  end
            endcase
        end
    end

    // sign-normalized area and edge terms
    always_comb
    begin
        na       = a_reg[CROSS_W-1] ? -a_reg  : a_reg;
        nb1      = a_reg[CROSS_W-1] ? -b1_reg : b1_reg;
        nb2      = a_reg[CROSS_W-1] ? -b2_reg : b2_reg;
        nsum     = nb1 + nb2;
        covered  = (a_reg != '0) && !nb1[CROSS_W-1] && !nb2[CROSS_W-1] && (nsum <= na);
        onscreen = ({{(SCR_W-COORD_W){1'b0}}, px_reg} < SCR_W'(SCREEN_WIDTH))
                && ({{(SCR_W-COORD_W){1'b0}}, py_reg} < SCR_W'(SCREEN_HEIGHT));
        r1_sh    = {r1_reg[AREA_W-1:0], 1'b0};
        r2_sh    = {r2_reg[AREA_W-1:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= 1'b0;
            pmac_reg   <= 1'b0;
            step_reg   <= '0;
            vi_reg     <= '0;
            qi_reg     <= '0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            pvalid_reg <= ctl.issue_cross || ctl.issue_mac;
            pmac_reg   <= ctl.issue_mac;
            if (accept)
            begin
                step_reg <= '0;
                vi_reg   <= '0;
                qi_reg   <= '0;
            end
            else if (ctl.issue_cross || ctl.div_run)
            begin
                step_reg <= (step_reg == CROSS_LAST && ctl.issue_cross) ? '0 : step_reg + 1'b1;
            end
            else if (ctl.issue_mac)
            begin
                if (vi_reg == LANE_LAST)
                begin
                    vi_reg <= '0;
                    qi_reg <= qi_reg + 1'b1;
                end
                else
                begin
                    vi_reg <= vi_reg + 1'b1;
                end
            end
            if (ctl.check)
            begin
                hit_reg <= covered && onscreen;
            end
        end
    end

    // datapath: diffs, products, accumulators, dividers
    always_ff @(posedge clk)
    begin
        prod_reg  <= mul_a * mul_b;
        tag_reg   <= step_reg;
        tag_q_reg <= qi_reg;
        if (accept)
        begin
            px_reg   <= x_coord;
            py_reg   <= y_coord;
            addr_reg <= in_addr;
            ex1_reg  <= DIFF_W'({1'b0, vx_reg[1]}) - DIFF_W'({1'b0, vx_reg[0]});
            ey1_reg  <= DIFF_W'({1'b0, vy_reg[1]}) - DIFF_W'({1'b0, vy_reg[0]});
            ex2_reg  <= DIFF_W'({1'b0, vx_reg[2]}) - DIFF_W'({1'b0, vx_reg[0]});
            ey2_reg  <= DIFF_W'({1'b0, vy_reg[2]}) - DIFF_W'({1'b0, vy_reg[0]});
            dx_reg   <= DIFF_W'({1'b0, vx_reg[0]}) - DIFF_W'({1'b0, x_coord});
            dy_reg   <= DIFF_W'({1'b0, vy_reg[0]}) - DIFF_W'({1'b0, y_coord});
            a_reg    <= '0;
            b1_reg   <= '0;
            b2_reg   <= '0;
            dsum_reg <= '0;
            usum_reg <= '0;
            vsum_reg <= '0;
        end
        else if (pvalid_reg && !pmac_reg)
        begin
            case (tag_reg)
                4'd0:    a_reg  <= a_reg  + prod_reg[CROSS_W-1:0];
                4'd1:    a_reg  <= a_reg  - prod_reg[CROSS_W-1:0];
                4'd2:    b2_reg <= b2_reg + prod_reg[CROSS_W-1:0];
                4'd3:    b2_reg <= b2_reg - prod_reg[CROSS_W-1:0];
                4'd4:    b1_reg <= b1_reg + prod_reg[CROSS_W-1:0];
                default: b1_reg <= b1_reg - prod_reg[CROSS_W-1:0];
            endcase
        end
        else if (pvalid_reg && pmac_reg)
        begin
            case (tag_q_reg)
                QTY_DEPTH: dsum_reg <= dsum_reg + prod_reg[ACC_W-1:0];
                QTY_U:     usum_reg <= usum_reg + prod_reg[ACC_W-1:0];
                default:   vsum_reg <= vsum_reg + prod_reg[ACC_W-1:0];
            endcase
        end

        if (ctl.check)
        begin
            area_reg <= na[AREA_W-1:0];
            if (nb1 >= na)
            begin
                r1_reg <= (AREA_W+1)'(nb1 - na);
                q1_reg <= QUO_W'(1);
            end
            else
            begin
                r1_reg <= nb1[AREA_W:0];
                q1_reg <= '0;
            end
            if (nb2 >= na)
            begin
                r2_reg <= (AREA_W+1)'(nb2 - na);
                q2_reg <= QUO_W'(1);
            end
            else
            begin
                r2_reg <= nb2[AREA_W:0];
                q2_reg <= '0;
            end
        end
        else if (ctl.div_run)
        begin
            if (r1_sh >= {1'b0, area_reg})
            begin
                r1_reg <= r1_sh - {1'b0, area_reg};
                q1_reg <= {q1_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                r1_reg <= r1_sh;
                q1_reg <= {q1_reg[QUO_W-2:0], 1'b0};
            end
            if (r2_sh >= {1'b0, area_reg})
            begin
                r2_reg <= r2_sh - {1'b0, area_reg};
                q2_reg <= {q2_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                r2_reg <= r2_sh;
                q2_reg <= {q2_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    // depth test and store update
    assign depth_calc = dsum_reg[FRAC_W +: DEPTH_W];
    assign pass       = hit_reg && (depth_calc > stored_depth);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = depth_calc;
        if (ctl.clearing)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = DEPTH_MIN;
        end
        else if (ctl.finish && pass)
        begin
            ram_we = 1'b1;
        end
    end

    tfdi_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (STORE_DEPTH)
    ) u_depth_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_addr),
        .rdata (stored_depth)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= (accept && opcode == OP_LOAD) || ctl.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && opcode == OP_LOAD)
        begin
            written_reg   <= 1'b0;
            out_x_reg     <= x_coord;
            out_y_reg     <= y_coord;
            out_depth_reg <= '0;
            out_u_reg     <= '0;
            out_v_reg     <= '0;
        end
        else if (ctl.finish)
        begin
            written_reg   <= pass;
            out_x_reg     <= px_reg;
            out_y_reg     <= py_reg;
            out_depth_reg <= pass ? depth_calc : '0;
            out_u_reg     <= pass ? usum_reg[FRAC_W +: TEX_W] : '0;
            out_v_reg     <= pass ? vsum_reg[FRAC_W +: TEX_W] : '0;
        end
    end

    assign strobe    = strobe_reg;
    assign written   = written_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_depth = out_depth_reg;
    assign out_u     = out_u_reg;
    assign out_v     = out_v_reg;

    a_written_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && written_reg |-> $past(state_reg == ST_FINISH))
        else $error("written result without a depth-test cycle");

    a_store_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_FINISH))
        else $error("depth store written outside clear or finish");

    a_finish_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH |=> strobe_reg)
        else $error("pixel test ended without a result");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !accept)
        else $error("transfer during depth store clear");

endmodule

// File: tb/triangle_fragment_depth_interpolate_top_tb.sv
// Testbench for the triangle fragment depth interpolator: vertex loads and pixel tests,
// checked against a scoreboard that models the vertices, barycentric math and depth store.
// Depends on tfdi_pkg and the triangle_fragment_depth_interpolate_top RTL.
module triangle_fragment_depth_interpolate_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tfdi_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int ITEM_COUNT = 1100;

    typedef struct {
        logic                      written;
        logic [COORD_W-1:0]        x;
        logic [COORD_W-1:0]        y;
        logic signed [DEPTH_W-1:0] depth;
        logic [TEX_W-1:0]          u;
        logic [TEX_W-1:0]          v;
    } fragment_t;

    class fragment_scoreboard;
        int vx[3];
        int vy[3];
        int vdepth[3];
        int vu[3];
        int vv[3];
        logic signed [DEPTH_W-1:0] zbuf[STORE_DEPTH];
        fragment_t expected_q[$];
        int mismatches;
        int loads;
        int pixels;
        int fragments;
        int checked;

        function new();
            for (int i = 0; i < 3; i++)
            begin
                vx[i] = 0; vy[i] = 0; vdepth[i] = 0; vu[i] = 0; vv[i] = 0;
            end
            for (int i = 0; i < STORE_DEPTH; i++)
                zbuf[i] = DEPTH_MIN;
            mismatches = 0; loads = 0; pixels = 0; fragments = 0; checked = 0;
        endfunction

        function void note_transfer(opcode_t op, logic [1:0] slot, logic [COORD_W-1:0] px,
                                    logic [COORD_W-1:0] py, logic signed [DEPTH_W-1:0] d,
                                    logic [TEX_W-1:0] tu, logic [TEX_W-1:0] tv);
            fragment_t f;
            longint ex1, ey1, ex2, ey2, dx, dy, area, b1, b2, w0, w1, w2, ds, us, vs;
            logic signed [DEPTH_W-1:0] z;
            int idx;
            f.written = 1'b0; f.x = px; f.y = py; f.depth = '0; f.u = '0; f.v = '0;
            if (op == OP_LOAD)
            begin
                loads++;
                if (slot != SLOT_NONE)
                begin
                    vx[slot] = px; vy[slot] = py; vdepth[slot] = d;
                    vu[slot] = tu; vv[slot] = tv;
                end
                expected_q.push_back(f);
                return;
            end
            pixels++;
            ex2 = vx[2] - vx[0]; ey2 = vy[2] - vy[0];
            ex1 = vx[1] - vx[0]; ey1 = vy[1] - vy[0];
            dx = vx[0] - longint'(px); dy = vy[0] - longint'(py);
            area = ex2 * ey1 - ex1 * ey2;
            b2 = ex1 * dy - dx * ey1;
            b1 = dx * ey2 - ex2 * dy;
            if (area < 0)
            begin
                area = -area; b1 = -b1; b2 = -b2;
            end
            if (area != 0 && b1 >= 0 && b2 >= 0 && b1 + b2 <= area)
            begin
                w1 = (b1 * 32768) / area;
                w2 = (b2 * 32768) / area;
                w0 = 32768 - w1 - w2;
                ds = w0 * vdepth[0] + w1 * vdepth[1] + w2 * vdepth[2];
                us = w0 * vu[0] + w1 * vu[1] + w2 * vu[2];
                vs = w0 * vv[0] + w1 * vv[1] + w2 * vv[2];
                z = DEPTH_W'(ds >>> 15);
                idx = int'(px) + SCREEN_WIDTH * int'(py);
                if (z > zbuf[idx])
                begin
                    zbuf[idx] = z;
                    fragments++;
                    f.written = 1'b1; f.depth = z;
                    f.u = TEX_W'(us >> 15); f.v = TEX_W'(vs >> 15);
                end
            end
            expected_q.push_back(f);
        endfunction

        function void check_result(fragment_t got);
            fragment_t exp_f;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result x=%0d y=%0d", $realtime, got.x, got.y);
                return;
            end
            exp_f = expected_q.pop_front();
            checked++;
            if (got.written !== exp_f.written || got.x !== exp_f.x || got.y !== exp_f.y ||
                got.depth !== exp_f.depth || got.u !== exp_f.u || got.v !== exp_f.v)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: mismatch exp w=%0b x=%0d y=%0d z=%0d u=%h v=%h",
                             $realtime, exp_f.written, exp_f.x, exp_f.y, exp_f.depth,
                             exp_f.u, exp_f.v);
                    $display("%0t:          got w=%0b x=%0d y=%0d z=%0d u=%h v=%h",
                             $realtime, got.written, got.x, got.y, got.depth, got.u, got.v);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      opcode = 1'b0;
    logic [1:0]                vertex_slot = '0;
    logic [COORD_W-1:0]        x_coord = '0;
    logic [COORD_W-1:0]        y_coord = '0;
    logic signed [DEPTH_W-1:0] vertex_depth = '0;
    logic [TEX_W-1:0]          tex_u = '0;
    logic [TEX_W-1:0]          tex_v = '0;
    logic                      strobe;
    logic                      written;
    logic [COORD_W-1:0]        out_x;
    logic [COORD_W-1:0]        out_y;
    logic signed [DEPTH_W-1:0] out_depth;
    logic [TEX_W-1:0]          out_u;
    logic [TEX_W-1:0]          out_v;

    fragment_scoreboard sb = new();
    int idle_pct = 0;
    int sent = 0;
    int quiet_cycles = 0;

    always #2 clk = ~clk;

    triangle_fragment_depth_interpolate_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .opcode(opcode),
        .vertex_slot(vertex_slot), .x_coord(x_coord), .y_coord(y_coord),
        .vertex_depth(vertex_depth), .tex_u(tex_u), .tex_v(tex_v), .strobe(strobe),
        .written(written), .out_x(out_x), .out_y(out_y), .out_depth(out_depth),
        .out_u(out_u), .out_v(out_v)
    );

    always @(posedge clk)
    begin
        fragment_t got;
        if (rst_n && strobe)
        begin
            got.written = written; got.x = out_x; got.y = out_y;
            got.depth = out_depth; got.u = out_u; got.v = out_v;
            sb.check_result(got);
        end
        if (rst_n && (strobe || (start && !busy)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", sb.pending());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_item(opcode_t op, logic [1:0] slot, int px, int py, int d,
                             int tu, int tv);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        opcode <= op;
        vertex_slot <= slot;
        x_coord <= COORD_W'(px);
        y_coord <= COORD_W'(py);
        vertex_depth <= DEPTH_W'(d);
        tex_u <= TEX_W'(tu);
        tex_v <= TEX_W'(tv);
        do @(posedge clk); while (busy);
        sb.note_transfer(op, slot, COORD_W'(px), COORD_W'(py), DEPTH_W'(d), TEX_W'(tu),
                         TEX_W'(tv));
        sent++;
    endtask

    task automatic load_vertex(int slot, int px, int py, int d, int tu, int tv);
        send_item(OP_LOAD, 2'(slot), px, py, d, tu, tv);
    endtask

    task automatic test_pixel(int px, int py);
        send_item(OP_PIXEL, 2'($urandom_range(3)), px, py, $urandom_range(32767) - 16384,
                  $urandom_range(65535), $urandom_range(65535));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic triangle_burst();
        int base_x, base_y, span, lo_x, lo_y, hi_x, hi_y, px, py, n;
        int xs[3];
        int ys[3];
        span = ($urandom_range(9) == 0) ? 511 : $urandom_range(40, 1);
        base_x = $urandom_range(511 - span);
        base_y = $urandom_range(511 - span);
        lo_x = 511; lo_y = 511; hi_x = 0; hi_y = 0;
        for (int i = 0; i < 3; i++)
        begin
            xs[i] = base_x + $urandom_range(span);
            ys[i] = base_y + $urandom_range(span);
            if (xs[i] < lo_x) lo_x = xs[i];
            if (xs[i] > hi_x) hi_x = xs[i];
            if (ys[i] < lo_y) lo_y = ys[i];
            if (ys[i] > hi_y) hi_y = ys[i];
            load_vertex(i, xs[i], ys[i], $urandom_range(32767) - 16384,
                        $urandom_range(65535), $urandom_range(65535));
        end
        n = $urandom_range(10, 3);
        for (int k = 0; k < n; k++)
        begin
            px = $urandom_range(hi_x, lo_x);
            py = $urandom_range(hi_y, lo_y);
            test_pixel(px, py);
        end
    endtask

    task automatic noise_item();
        send_item(opcode_t'($urandom_range(1)), 2'($urandom_range(3)), $urandom_range(511),
                  $urandom_range(511), $urandom_range(32767) - 16384, $urandom_range(65535),
                  $urandom_range(65535));
    endtask

    initial
    begin
        int phase_end;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        load_vertex(3, 511, 511, -16384, 65535, 65535);
        test_pixel(0, 0);
        load_vertex(0, 0, 0, 16383, 0, 65535);
        load_vertex(1, 511, 0, -16384, 65535, 0);
        load_vertex(2, 0, 511, 0, 32768, 1);
        test_pixel(0, 0);
        test_pixel(100, 100);
        test_pixel(511, 511);
        test_pixel(255, 256);
        test_pixel(511, 0);
        test_pixel(100, 100);
        load_vertex(1, 0, 511, 16383, 65535, 65535);
        load_vertex(2, 511, 0, 16383, 65535, 65535);
        test_pixel(50, 60);
        test_pixel(100, 100);
        load_vertex(2, 0, 0, 5, 7, 9);
        test_pixel(0, 100);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 0) ? 0 : (ph == 1) ? 88 : (ph == 2) ? 22 : 0;
            phase_end = sent + ITEM_COUNT / 4;
            while (sent < phase_end)
            begin
                if ($urandom_range(99) < 15)
                    noise_item();
                else
                    triangle_burst();
            end
            drain();
        end

        repeat (40) @(posedge clk);
        $display("covered %0d vertex loads and %0d pixel tests, %0d fragments written",
                 sb.loads, sb.pixels, sb.fragments);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
